// ----- hdl/fps_pkg.sv -----
package fps_pkg;

  localparam int ENTRY_INDEX_W = 10;
  localparam int WORD_W        = 16;
  localparam int PHASE_W       = 12;
  localparam int DROP_W        = 9;
  localparam int LINE_W        = 9;

  // Operation codes carried in the operation field of an input transfer.
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_WRITE_INC  = 3'd1;
  localparam logic [2:0] OP_WRITE_ACC  = 3'd2;
  localparam logic [2:0] OP_START_DROP = 3'd3;
  localparam logic [2:0] OP_READ_ACC   = 3'd4;

  // Register select, taken from bit 3 of the byte address.
  localparam logic CFG_L_PHASES = 1'b0;
  localparam logic CFG_K_PHASES = 1'b1;

  localparam logic [LINE_W-1:0] LINE_REST   = 9'd60;
  localparam logic [LINE_W-1:0] LINE_RELOAD = 9'd400;
  localparam logic [9:0]        FADE_A_END   = 10'd96;
  localparam logic [9:0]        FADE_B_START = 10'd128;
  localparam logic [9:0]        DROP_MAX     = 10'd256;
  localparam logic [15:0]       LINE_SCALE   = 16'd43;

  // Per-frame phase steps modulo 4096; entry 0 sits in the low bits.
  localparam logic [3:0][PHASE_W-1:0] K_STEP = {12'd2, 12'd1, 12'd4094, 12'd4093};
  localparam logic [3:0][PHASE_W-1:0] L_STEP = {12'd3, 12'd2, 12'd4094, 12'd4095};

  typedef struct packed {
    logic [2:0]               operation;
    logic [ENTRY_INDEX_W-1:0] entry_index;
    logic [WORD_W-1:0]        entry_value;
  } fps_item_t;

  typedef struct packed {
    logic [LINE_W-1:0]        line_compare;
    logic                     line_compare_set;
    logic                     upload_palette;
    logic [31:0]              frame_number;
    logic [47:0]              l_phase_word;
    logic [47:0]              k_phase_word;
    logic [DROP_W-1:0]        drop_step;
    logic [WORD_W-1:0]        read_word;
  } fps_result_t;

  typedef struct packed {
    logic                     rd_en;
    logic [ENTRY_INDEX_W-1:0] rd_addr;
    logic                     inc_we;
    logic                     acc_we;
    logic                     acc_fade;
    logic [ENTRY_INDEX_W-1:0] wr_addr;
    logic [WORD_W-1:0]        wr_data;
  } fps_pal_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LINE,
    ST_FADE,
    ST_READ,
    ST_EMIT
  } fps_state_t;

endpackage

// ----- hdl/fps_palette_ram.sv -----
module fps_palette_ram #(
  parameter int ENTRIES = 768
) (
  input  logic                 clk,
  input  fps_pkg::fps_pal_cmd_t cmd,
  output logic [15:0]          acc_q
);
  import fps_pkg::*;

  localparam int AW = $clog2(ENTRIES);

  logic [WORD_W-1:0] accum [ENTRIES];
  logic [WORD_W-1:0] incr  [ENTRIES];
  logic [WORD_W-1:0] inc_q;

  // During a fade the write-back uses the words read in the cycle before.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      acc_q <= accum[cmd.rd_addr[AW-1:0]];
      inc_q <= incr[cmd.rd_addr[AW-1:0]];
    end
    if (cmd.acc_we) begin
      accum[cmd.wr_addr[AW-1:0]] <= cmd.acc_fade ? acc_q + inc_q : cmd.wr_data;
    end
    if (cmd.inc_we) begin
      incr[cmd.wr_addr[AW-1:0]] <= cmd.wr_data;
    end
  end

endmodule

// ----- hdl/frame_split_and_palette_fade_sequencer_core.sv -----
// Frame split and palette fade sequencer.
//
// One input transfer carries one operation: a frame tick, a write into either
// palette table, the start of a drop sequence, or a read of one accumulator.
// Every accepted transfer yields exactly one result transfer, in order.
//
// The block works on one item at a time. Writes, drop starts, undefined
// operations and ticks that neither compute a split line nor fade go straight
// from execute to emit; in-range reads pass a read state, split-line ticks a
// line state. The next item is taken in the cycle after its result is
// registered. A fading tick sweeps both tables, one entry a cycle.
//
// The result sits in an output register, so the next item is accepted while
// a finished result still waits; if the receiver stalls, the following result
// is held back until the register is free, and no new item is taken meanwhile.
//
// Synchronous reset clears the counters, phases, flags and the two phase reload
// registers. The palette tables are not cleared and must be written before they
// are faded or read. The user must write the reload registers over the APB port
// at byte addresses 0 and 8 only while idle, which the block does not enforce.
module frame_split_and_palette_fade_sequencer_core #(
  parameter int PALETTE_ENTRIES = 768,
  parameter int DROP_STEPS      = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  input  logic                item_valid,
  output logic                item_stall,
  input  fps_pkg::fps_item_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output fps_pkg::fps_result_t result
);
  import fps_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam logic [10:0] ENTRY_LIMIT = 11'(PALETTE_ENTRIES);
  localparam logic [AW:0] SWEEP_END   = (AW+1)'(PALETTE_ENTRIES);
  localparam logic [9:0]  LINE_LAST   = 10'(DROP_STEPS);
  localparam logic [9:0]  RELOAD_STEP = 10'(DROP_STEPS + 1);

  fps_state_t state, state_next;

  fps_item_t              cur;
  logic [47:0]            init_l, init_k;
  logic [31:0]            frame_counter;
  logic                   upload_pending;
  logic [DROP_W-1:0]      drop_counter;
  logic [3:0][PHASE_W-1:0] l_phase, k_phase;

  logic [LINE_W-1:0]      res_line;
  logic                   res_line_set;
  logic                   res_upload;
  logic [WORD_W-1:0]      res_read;
  logic [12:0]            sq;
  logic [AW:0]            sweep_cnt;
  logic                   wb_valid;
  logic [AW-1:0]          wb_addr;

  fps_pal_cmd_t           pal_cmd;
  logic [WORD_W-1:0]      acc_q;

  logic                   in_range;
  logic [9:0]             drop_n;
  logic                   drop_running;
  logic                   step_line, step_reload, step_fade;
  logic                   emit_go;
  logic [15:0]            line_prod;

  // ---------------------------------------------------------------------
  // Configuration port. Bit 3 of the byte address picks the register;
  // the lower bits are ignored.
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[3] == CFG_K_PHASES) ? {16'd0, init_k} : {16'd0, init_l};

  always_ff @(posedge clk) begin
    if (rst) begin
      init_l <= '0;
      init_k <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3])
        CFG_L_PHASES: init_l <= pwdata[47:0];
        CFG_K_PHASES: init_k <= pwdata[47:0];
        default:      init_l <= init_l;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Decode of the current item and of the next drop step.
  // ---------------------------------------------------------------------
  assign in_range     = {1'b0, cur.entry_index} < ENTRY_LIMIT;
  assign drop_n       = {1'b0, drop_counter} + 10'd1;
  assign drop_running = (cur.operation == OP_TICK) && (drop_counter != '0);

  // The steps are tested in order: the split descent first, then the single
  // reload step, then the two fading windows; anything else ends the drop.
  always_comb begin
    step_line   = 1'b0;
    step_reload = 1'b0;
    step_fade   = 1'b0;
    priority if (drop_n <= LINE_LAST) begin
      step_line = 1'b1;
    end else if (drop_n == RELOAD_STEP) begin
      step_reload = 1'b1;
    end else if (drop_n <= FADE_A_END || (drop_n >= FADE_B_START && drop_n < DROP_MAX)) begin
      step_fade = 1'b1;
    end else begin
      step_fade = 1'b0;
    end
  end

  assign emit_go    = !result_valid || !result_stall;
  assign item_stall = (state != ST_IDLE);

  // Split line from the squared step held in sq: n*n/4*43/128 + 60.
  assign line_prod = 16'(sq[12:2]) * LINE_SCALE;

  // ---------------------------------------------------------------------
  // Sequencer: next state and palette table commands.
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    pal_cmd    = '0;
    unique case (state)
      ST_IDLE: begin
        if (item_valid && !item_stall) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next       = ST_EMIT;
        pal_cmd.wr_addr  = cur.entry_index;
        pal_cmd.wr_data  = cur.entry_value;
        pal_cmd.rd_addr  = cur.entry_index;
        unique case (cur.operation)
          OP_TICK: begin
            if (drop_running && step_line) begin
              state_next = ST_LINE;
            end else if (drop_running && step_fade) begin
              state_next = ST_FADE;
            end
          end
          OP_WRITE_INC: pal_cmd.inc_we = in_range;
          OP_WRITE_ACC: pal_cmd.acc_we = in_range;
          OP_READ_ACC: begin
            if (in_range) begin
              pal_cmd.rd_en = 1'b1;
              state_next    = ST_READ;
            end
          end
          default: state_next = ST_EMIT;
        endcase
      end
      ST_LINE: state_next = ST_EMIT;
      ST_READ: state_next = ST_EMIT;
      ST_FADE: begin
        // Read entry sweep_cnt while writing back entry sweep_cnt - 1.
        pal_cmd.rd_en    = (sweep_cnt < SWEEP_END);
        pal_cmd.rd_addr  = ENTRY_INDEX_W'(sweep_cnt[AW-1:0]);
        pal_cmd.acc_we   = wb_valid;
        pal_cmd.acc_fade = 1'b1;
        pal_cmd.wr_addr  = ENTRY_INDEX_W'(wb_addr);
        if (sweep_cnt == SWEEP_END) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  fps_palette_ram #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .cmd   (pal_cmd),
    .acc_q (acc_q)
  );

  // ---------------------------------------------------------------------
  // Architectural state: frame counter, phases, drop counter, upload flag.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter  <= '0;
      upload_pending <= 1'b0;
      drop_counter   <= '0;
      l_phase        <= '0;
      k_phase        <= '0;
      wb_valid       <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      wb_valid <= (state == ST_FADE) && (sweep_cnt < SWEEP_END);
      if (state == ST_EXEC && cur.operation == OP_TICK) begin
        frame_counter  <= frame_counter + 32'd1;
        upload_pending <= 1'b0;
        for (int i = 0; i < 4; i++) begin
          l_phase[i] <= l_phase[i] + L_STEP[i];
          k_phase[i] <= k_phase[i] + K_STEP[i];
        end
        if (drop_running) begin
          drop_counter <= drop_n[DROP_W-1:0];
          if (step_reload) begin
            l_phase        <= init_l;
            k_phase        <= init_k;
            upload_pending <= 1'b1;
          end else if (step_fade) begin
            upload_pending <= 1'b1;
          end else if (!step_line) begin
            drop_counter <= '0;
          end
        end
      end else if (state == ST_EXEC && cur.operation == OP_START_DROP) begin
        drop_counter <= (cur.entry_value > 16'(DROP_MAX)) ? DROP_MAX[DROP_W-1:0]
                                                          : cur.entry_value[DROP_W-1:0];
      end
      if (state == ST_EMIT && emit_go) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers: captured item, per-item result fields, sweep.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid && !item_stall) begin
      cur <= item;
    end
    unique case (state)
      ST_EXEC: begin
        res_line     <= '0;
        res_line_set <= 1'b0;
        res_read     <= '0;
        res_upload   <= (cur.operation == OP_TICK) ? upload_pending : 1'b0;
        sweep_cnt    <= '0;
        sq           <= 13'(drop_n[6:0]) * 13'(drop_n[6:0]);
        if (drop_running && step_reload) begin
          res_line     <= LINE_RELOAD;
          res_line_set <= 1'b1;
        end else if (drop_running && step_fade) begin
          res_line     <= LINE_REST;
          res_line_set <= 1'b1;
        end else if (drop_running && step_line) begin
          res_line_set <= 1'b1;
        end
      end
      ST_LINE: res_line <= line_prod[15:7] + LINE_REST;
      ST_READ: res_read <= acc_q;
      ST_FADE: begin
        sweep_cnt <= sweep_cnt + (AW+1)'(1);
        wb_addr   <= sweep_cnt[AW-1:0];
      end
      default: sweep_cnt <= sweep_cnt;
    endcase
    if (state == ST_EMIT && emit_go) begin
      result.line_compare     <= res_line;
      result.line_compare_set <= res_line_set;
      result.upload_palette   <= res_upload;
      result.frame_number     <= frame_counter;
      result.l_phase_word     <= l_phase;
      result.k_phase_word     <= k_phase;
      result.drop_step        <= drop_counter;
      result.read_word        <= res_read;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // The fade write-back always trails the read address by one entry.
  a_fade_trail: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FADE && wb_valid) |-> ({1'b0, wb_addr} == sweep_cnt - (AW+1)'(1)))
    else $error("fade write-back address out of step with the read sweep");

  // A result leaving the sequencer lands in the output register and frees
  // the block for the next item.
  a_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && emit_go) |=> (result_valid && state == ST_IDLE))
    else $error("result not registered after emit");

  // The drop counter never runs past its clamp value.
  a_drop_max: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, drop_counter} <= DROP_MAX))
    else $error("drop counter beyond its maximum");

  // A set split line never lies below the resting line.
  a_line_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.line_compare_set) |-> (result.line_compare >= LINE_REST))
    else $error("split line below its minimum");

endmodule

// ----- tb/fps_sequencer_checker.sv -----
module fps_sequencer_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 pready,
  input  logic [3:0]           paddr,
  input  logic [63:0]          pwdata,
  input  logic                 item_valid,
  input  logic                 item_stall,
  input  fps_pkg::fps_item_t   item,
  input  logic                 result_valid,
  input  logic                 result_stall,
  input  fps_pkg::fps_result_t result,
  output int                   mismatches,
  output int                   pending,
  output int                   checked,
  output int                   fade_ticks,
  output int                   reload_ticks
);
  timeunit 1ns;
  timeprecision 1ps;
  import fps_pkg::*;

  localparam int TABLE_DEPTH       = 768;
  localparam int SPLIT_STEPS       = 64;
  localparam int FIRST_FADE_END    = 96;
  localparam int SECOND_FADE_START = 128;
  localparam int DROP_CEILING      = 256;
  localparam int REST_LINE         = 60;
  localparam int RELOAD_LINE       = 400;
  localparam int SPLIT_SCALE       = 43;
  localparam int SPLIT_DIVISOR     = 128;
  localparam int REPORT_LIMIT      = 10;

  logic [15:0]      accum_mirror [TABLE_DEPTH];
  logic [15:0]      increment_mirror [TABLE_DEPTH];
  logic [3:0][11:0] l_phases;
  logic [3:0][11:0] k_phases;
  logic [47:0]      l_reload;
  logic [47:0]      k_reload;
  logic [8:0]       drop_count;
  logic             upload_flag;
  logic [31:0]      frame_tally;
  fps_result_t      expected_results[$];
  fps_result_t      oldest;

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("[%0t] %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  // Applies one operation to the mirrored state and returns the result it should produce.
  function automatic fps_result_t advance_sequencer(input fps_item_t it);
    fps_result_t r;
    int n;
    r = '0;
    case (it.operation)
      OP_TICK: begin
        frame_tally = frame_tally + 32'd1;
        r.upload_palette = upload_flag;
        upload_flag = 1'b0;
        k_phases[0] = k_phases[0] - 12'd3;
        k_phases[1] = k_phases[1] - 12'd2;
        k_phases[2] = k_phases[2] + 12'd1;
        k_phases[3] = k_phases[3] + 12'd2;
        l_phases[0] = l_phases[0] - 12'd1;
        l_phases[1] = l_phases[1] - 12'd2;
        l_phases[2] = l_phases[2] + 12'd2;
        l_phases[3] = l_phases[3] + 12'd3;
        if (drop_count != 9'd0) begin
          n = int'(drop_count) + 1;
          drop_count = 9'(n);
          if (n <= SPLIT_STEPS) begin
            r.line_compare = 9'((n * n / 4) * SPLIT_SCALE / SPLIT_DIVISOR + REST_LINE);
            r.line_compare_set = 1'b1;
          end else if (n == SPLIT_STEPS + 1) begin
            r.line_compare = 9'(RELOAD_LINE);
            r.line_compare_set = 1'b1;
            l_phases = l_reload;
            k_phases = k_reload;
            upload_flag = 1'b1;
            reload_ticks++;
          end else if (n <= FIRST_FADE_END || (n >= SECOND_FADE_START && n < DROP_CEILING)) begin
            r.line_compare = 9'(REST_LINE);
            r.line_compare_set = 1'b1;
            for (int e = 0; e < TABLE_DEPTH; e++)
              accum_mirror[e] = accum_mirror[e] + increment_mirror[e];
            upload_flag = 1'b1;
            fade_ticks++;
          end else begin
            drop_count = '0;
          end
        end
      end
      OP_WRITE_INC: begin
        if (it.entry_index < TABLE_DEPTH) increment_mirror[it.entry_index] = it.entry_value;
      end
      OP_WRITE_ACC: begin
        if (it.entry_index < TABLE_DEPTH) accum_mirror[it.entry_index] = it.entry_value;
      end
      OP_START_DROP: begin
        drop_count = (it.entry_value > DROP_CEILING) ? 9'(DROP_CEILING) : 9'(it.entry_value);
      end
      OP_READ_ACC: begin
        if (it.entry_index < TABLE_DEPTH) r.read_word = accum_mirror[it.entry_index];
      end
      default: ;
    endcase
    r.frame_number = frame_tally;
    r.l_phase_word = l_phases;
    r.k_phase_word = k_phases;
    r.drop_step    = drop_count;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      l_phases     = '0;
      k_phases     = '0;
      l_reload     = '0;
      k_reload     = '0;
      drop_count   = '0;
      upload_flag  = 1'b0;
      frame_tally  = '0;
      mismatches   = 0;
      checked      = 0;
      fade_ticks   = 0;
      reload_ticks = 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {CFG_L_PHASES, 3'b000}) l_reload = pwdata[47:0];
        else if (paddr == {CFG_K_PHASES, 3'b000}) k_reload = pwdata[47:0];
      end
      if (result_valid && !result_stall) begin
        checked++;
        if (expected_results.size() == 0) begin
          note_mismatch("result transfer with nothing expected, frame_number", '0,
                        64'(result.frame_number));
        end else begin
          oldest = expected_results.pop_front();
          if (result.line_compare !== oldest.line_compare)
            note_mismatch("line_compare", 64'(oldest.line_compare),
                          64'(result.line_compare));
          if (result.line_compare_set !== oldest.line_compare_set)
            note_mismatch("line_compare_set", 64'(oldest.line_compare_set),
                          64'(result.line_compare_set));
          if (result.upload_palette !== oldest.upload_palette)
            note_mismatch("upload_palette", 64'(oldest.upload_palette),
                          64'(result.upload_palette));
          if (result.frame_number !== oldest.frame_number)
            note_mismatch("frame_number", 64'(oldest.frame_number),
                          64'(result.frame_number));
          if (result.l_phase_word !== oldest.l_phase_word)
            note_mismatch("l_phase_word", 64'(oldest.l_phase_word),
                          64'(result.l_phase_word));
          if (result.k_phase_word !== oldest.k_phase_word)
            note_mismatch("k_phase_word", 64'(oldest.k_phase_word),
                          64'(result.k_phase_word));
          if (result.drop_step !== oldest.drop_step)
            note_mismatch("drop_step", 64'(oldest.drop_step), 64'(result.drop_step));
          if (result.read_word !== oldest.read_word)
            note_mismatch("read_word", 64'(oldest.read_word), 64'(result.read_word));
        end
      end
      if (item_valid && !item_stall)
        expected_results.push_back(advance_sequencer(item));
    end
    pending = expected_results.size();
  end

endmodule

// ----- tb/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fps_pkg::*;

  // The limit leaves room for every tick being a full palette sweep with the longest
  // stalls on both sides.
  localparam int LIMIT_CYCLES    = 3_000_000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int TABLE_DEPTH     = 768;

  localparam logic [3:0]  L_RELOAD_ADDR = {CFG_L_PHASES, 3'b000};
  localparam logic [3:0]  K_RELOAD_ADDR = {CFG_K_PHASES, 3'b000};
  localparam logic [63:0] ALL_ONES      = '1;

  // Operation codes the block does not define; they must leave the state alone.
  localparam logic [2:0] OP_UNUSED_LO = OP_READ_ACC + 3'd1;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        item_valid;
  logic        item_stall;
  fps_item_t   item;
  logic        result_valid;
  logic        result_stall;
  fps_result_t result;

  int mismatches;
  int pending;
  int checked;
  int fade_ticks;
  int reload_ticks;
  int transfers_sent;

  // Shared between the sender and the receiver: calm switches off idling on one side,
  // and the hold request asks the receiver for one long stall.
  bit tx_calm;
  bit rx_calm;
  bit hold_request;

  frame_split_and_palette_fade_sequencer_core uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  fps_sequencer_checker sequencer_check (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .mismatches   (mismatches),
    .pending      (pending),
    .checked      (checked),
    .fade_ticks   (fade_ticks),
    .reload_ticks (reload_ticks)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Most gaps are zero or short; now and then one is long enough to let the block
  // run dry or back up.
  function automatic int idle_len(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic fps_item_t make_item(input logic [2:0] op, input logic [9:0] index,
                                          input logic [15:0] value);
    fps_item_t it;
    it.operation   = op;
    it.entry_index = index;
    it.entry_value = value;
    return it;
  endfunction

  // Drop starts are biased towards the edges of the split, reload and fade windows, so
  // that a short burst of ticks still crosses them. A value of one gives the full sequence.
  function automatic logic [15:0] drop_start_value();
    case ($urandom_range(0, 9))
      0, 1:    return 16'd1;
      2:       return 16'd0;
      3:       return 16'($urandom);
      4:       return 16'($urandom_range(60, 68));
      5:       return 16'($urandom_range(92, 100));
      6:       return 16'($urandom_range(124, 132));
      7:       return 16'($urandom_range(250, 258));
      default: return 16'($urandom_range(1, 256));
    endcase
  endfunction

  // One item within a drop burst: mostly ticks, with table traffic, reads, the odd
  // restart of the drop and the odd undefined operation mixed in.
  function automatic fps_item_t burst_item();
    fps_item_t it;
    int pick;
    if ($urandom_range(0, 15) == 0)
      it.entry_index = 10'($urandom_range(TABLE_DEPTH, 1023));
    else
      it.entry_index = 10'($urandom_range(0, TABLE_DEPTH - 1));
    it.entry_value = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      it.operation = OP_TICK;
    end else if (pick < 70) begin
      it.operation = OP_WRITE_INC;
    end else if (pick < 78) begin
      it.operation = OP_WRITE_ACC;
    end else if (pick < 92) begin
      it.operation = OP_READ_ACC;
    end else if (pick < 96) begin
      it.operation   = OP_START_DROP;
      it.entry_value = drop_start_value();
    end else begin
      it.operation = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    end
    return it;
  endfunction

  // Offers one transfer and returns at the edge where it was taken. Valid is only lowered
  // when an idle gap comes first, so back-to-back transfers keep it high.
  task automatic send_item(input fps_item_t it);
    int gap;
    gap = idle_len(tx_calm);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    transfers_sent++;
  endtask

  // Waits until every expected result has come back, then lets the block settle. The
  // count is sampled on the falling edge so that it is never read mid-update.
  task automatic wait_until_drained();
    item_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [3:0] addr, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_reload_values(input logic [63:0] l_value, input logic [63:0] k_value);
    write_register(L_RELOAD_ADDR, l_value);
    write_register(K_RELOAD_ADDR, k_value);
  endtask

  // Sends drop bursts until the quota of transfers that do real work is reached. Each
  // burst opens with a drop start and then runs ticks and table traffic after it.
  task automatic run_bursts(input int quota);
    int counted;
    int burst_len;
    fps_item_t it;
    counted = 0;
    while (counted < quota) begin
      it = make_item(OP_START_DROP, 10'($urandom), drop_start_value());
      send_item(it);
      counted++;
      if (it.entry_value == 16'd1) burst_len = $urandom_range(100, 140);
      else burst_len = $urandom_range(4, 40);
      for (int j = 0; j < burst_len && counted < quota; j++) begin
        it = burst_item();
        send_item(it);
        // Undefined operations and writes beyond the tables are ignored by the block.
        if (it.operation <= OP_READ_ACC &&
            !((it.operation == OP_WRITE_INC || it.operation == OP_WRITE_ACC) &&
              it.entry_index >= TABLE_DEPTH))
          counted++;
      end
    end
  endtask

  // The receiver stalls in runs of random length, and once, on request, for a long
  // stretch counted here while the sender keeps offering transfers.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        stall_left = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
        if (!rx_calm && $urandom_range(0, 99) < 25) stall_left = idle_len(1'b0);
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    tx_calm      = 1'b0;
    rx_calm      = 1'b0;
    hold_request = 1'b0;
    transfers_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_reload_values({$urandom, $urandom}, {$urandom, $urandom});

    // The palette tables come out of reset undefined, so every entry of both is written
    // before anything can read or fade it.
    for (int e = 0; e < TABLE_DEPTH; e++) begin
      send_item(make_item(OP_WRITE_INC, 10'(e), 16'($urandom)));
      send_item(make_item(OP_WRITE_ACC, 10'(e), 16'($urandom)));
    end

    // Directed transfers: table edges, indexes beyond the tables, undefined operations,
    // the clamp on the drop start, a stop, and each boundary of the drop sequence.
    send_item(make_item(OP_READ_ACC, 10'd767, 16'h0000));
    send_item(make_item(OP_READ_ACC, 10'd1023, 16'hFFFF));
    send_item(make_item(OP_WRITE_ACC, 10'd767, 16'hFFFF));
    send_item(make_item(OP_WRITE_INC, 10'd767, 16'hFFFF));
    send_item(make_item(OP_WRITE_ACC, 10'd1023, 16'h0000));
    send_item(make_item(OP_WRITE_INC, 10'd768, 16'h1234));
    send_item(make_item(OP_READ_ACC, 10'd767, 16'h0000));
    send_item(make_item(OP_UNUSED_LO, 10'd1023, 16'hFFFF));
    send_item(make_item(OP_UNUSED_LO + 3'd1, 10'd0, 16'h0000));
    send_item(make_item(OP_UNUSED_HI, 10'd512, 16'h8000));
    // A start above the ceiling is clamped, and the next tick runs off the end.
    send_item(make_item(OP_START_DROP, 10'd0, 16'hFFFF));
    send_item(make_item(OP_TICK, '0, '0));
    send_item(make_item(OP_START_DROP, 10'd0, 16'h0000));
    send_item(make_item(OP_TICK, 10'd1023, 16'hFFFF));
    // Last split line, the reload tick, then the first fades with their upload flags.
    send_item(make_item(OP_START_DROP, 10'd0, 16'd63));
    repeat (4) send_item(make_item(OP_TICK, '0, '0));
    send_item(make_item(OP_START_DROP, 10'd0, 16'd96));
    send_item(make_item(OP_TICK, '0, '0));
    send_item(make_item(OP_START_DROP, 10'd0, 16'd127));
    send_item(make_item(OP_TICK, '0, '0));
    send_item(make_item(OP_START_DROP, 10'd0, 16'd255));
    send_item(make_item(OP_TICK, '0, '0));
    send_item(make_item(OP_TICK, '0, '0));
    send_item(make_item(OP_READ_ACC, 10'd767, 16'h0000));

    // Phase with all reload values at zero and idling on both sides.
    wait_until_drained();
    set_reload_values('0, '0);
    run_bursts(190);

    // Phase with every reload bit set and no idling anywhere.
    wait_until_drained();
    set_reload_values(ALL_ONES, ALL_ONES);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    run_bursts(150);
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    // The receiver holds off for a long stretch while the sender pushes on, so the block
    // fills and stalls its input; then the sender waits for every result to come back.
    wait_until_drained();
    set_reload_values({$urandom, $urandom}, {$urandom, $urandom});
    hold_request = 1'b1;
    tx_calm = 1'b1;
    run_bursts(60);
    tx_calm = 1'b0;
    wait_until_drained();
    run_bursts(150);

    wait_until_drained();
    set_reload_values({$urandom, $urandom}, '0);
    run_bursts(230);

    wait_until_drained();
    $display("Sent %0d transfers and compared %0d results, with %0d fading ticks and %0d",
             transfers_sent, checked, fade_ticks, reload_ticks);
    $display("phase reloads under zero, all-ones and random reload settings.");
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
